// ----- rtl/pic_pkg.sv -----
`timescale 1ns / 1ps
package pic_pkg;

  localparam int MaxTaxa   = 8;
  localparam int MaxSites  = 1024;
  localparam int NumAa     = 20;
  localparam int FracBits  = 30;
  localparam int AddrW     = $clog2(MaxTaxa * MaxSites);
  localparam int TaxW      = $clog2(MaxTaxa);
  localparam int SiteW     = $clog2(MaxSites);

  typedef logic [4:0] code_t;

  localparam code_t BadCode = 5'd31;
  localparam logic [7:0] DotChar = 8'h2E;

  localparam logic CfgTaxa  = 1'b0;
  localparam logic CfgSites = 1'b1;

  // Map an ASCII letter to its amino-acid code, everything else is invalid.
  function automatic code_t code_of(input logic [7:0] ch);
    code_t c;
    unique case (ch)
      "A": c = 5'd0;
      "R": c = 5'd1;
      "N": c = 5'd2;
      "D": c = 5'd3;
      "C": c = 5'd4;
      "Q": c = 5'd5;
      "E": c = 5'd6;
      "G": c = 5'd7;
      "H": c = 5'd8;
      "I": c = 5'd9;
      "L": c = 5'd10;
      "K": c = 5'd11;
      "M": c = 5'd12;
      "F": c = 5'd13;
      "P": c = 5'd14;
      "S": c = 5'd15;
      "T": c = 5'd16;
      "W": c = 5'd17;
      "Y": c = 5'd18;
      "V": c = 5'd19;
      default: c = BadCode;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/pairwise_identity_covariance_unit.sv -----
`timescale 1ns / 1ps
// Pairwise identity covariance of a protein alignment. Residues arrive as
// ASCII bytes, taxon by taxon and site by site; each transaction is one
// read of the residue memory (for the '.' copy of taxon 0) and then one
// write. After the last residue the block stops accepting and computes:
// it sums the 20 residue counts and their squares, counts matching and
// valid sites for each taxon pair through the two read ports of the residue
// memory, then computes each matrix entry with the single shared 27x14
// multiplier (three products for an off-diagonal entry, none for a diagonal
// one) and the one-bit-per-cycle restoring divider (31 steps plus rounding);
// an undefined entry skips the divider. Entries leave row-major through a
// held output register; each waits for out_ready.
// sigma_value is Q1.30, rounded to nearest, ties away from zero;
// undefined_flag marks a zero denominator and then sigma_value is zero.
// A configuration write restarts the load. The residue memory holds no reset.
module pairwise_identity_covariance_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  residue_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  row_taxon,
  output logic [2:0]  col_taxon,
  output logic signed [31:0] sigma_value,
  output logic        undefined_flag,
  output logic        last_entry
);

  localparam int AW = pic_pkg::AddrW;
  localparam int TW = pic_pkg::TaxW;
  localparam int SW = pic_pkg::SiteW;
  localparam int DW = 39;   // divider remainder / operand width

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_LDW  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_NS2  = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SACC = 4'd5;
  localparam logic [3:0] S_ERD  = 4'd6;
  localparam logic [3:0] S_EM1  = 4'd7;
  localparam logic [3:0] S_EM2  = 4'd8;
  localparam logic [3:0] S_EM3  = 4'd9;
  localparam logic [3:0] S_ESUB = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_RND  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]  state;
  logic [3:0]  taxa_reg;
  logic [10:0] sites_reg;

  // Effective configuration, clamped into range.
  logic [3:0]    eff_t;
  logic [10:0]   eff_s;
  logic [TW-1:0] nt_m1;
  always_comb begin
    if (taxa_reg == 4'd0) eff_t = 4'd1;
    else if (taxa_reg > 4'(pic_pkg::MaxTaxa)) eff_t = 4'(pic_pkg::MaxTaxa);
    else eff_t = taxa_reg;
    if (sites_reg == 11'd0) eff_s = 11'd1;
    else if (sites_reg > 11'(pic_pkg::MaxSites)) eff_s = 11'(pic_pkg::MaxSites);
    else eff_s = sites_reg;
  end
  assign nt_m1 = TW'(eff_t - 4'd1);

  // Load counters.
  logic [AW-1:0] pos;
  logic [TW-1:0] ld_taxon;
  logic [SW-1:0] ld_site;
  logic [7:0]    ch_r;

  // Residue counts.
  logic [13:0] freq [pic_pkg::NumAa];
  logic [4:0]  acnt;
  logic [13:0] ns;
  logic [26:0] qsum;
  logic [26:0] ns2;

  // Pair scan.
  logic [TW-1:0] ps, pt;
  logic [SW-1:0] h;
  logic [AW-1:0] base_s, base_t;
  logic [10:0]   cnt_m, cnt_p;
  pic_pkg::code_t rd_x, rd_y;

  // Emission.
  logic [TW-1:0] es, et;
  logic [21:0]   pm_rd;
  logic [DW-1:0] pos_r, neg_r, den_r, rem;
  logic [30:0]   quo;
  logic [4:0]    dcnt;
  logic          neg_sign;

  // Memories.
  pic_pkg::code_t store  [pic_pkg::MaxTaxa * pic_pkg::MaxSites];
  logic [21:0]    pm_mem [pic_pkg::MaxTaxa * pic_pkg::MaxTaxa];

  logic in_fire;
  assign in_ready = (state == S_LOAD);
  assign in_fire  = in_valid && in_ready;

  // Code of the residue being written: a dot past taxon 0 copies taxon 0.
  pic_pkg::code_t ld_code;
  always_comb begin
    if (ch_r == pic_pkg::DotChar && ld_taxon != '0) ld_code = rd_x;
    else ld_code = pic_pkg::code_of(ch_r);
  end

  logic ld_last;
  assign ld_last = (ld_taxon == nt_m1) && ({1'b0, ld_site} + 11'd1 == eff_s);

  // Scan compare.
  logic        both_ok, hit;
  logic [10:0] m_new, p_new;
  logic        h_last, pair_last_t, pair_last_s;
  assign both_ok = (rd_x < 5'(pic_pkg::NumAa)) && (rd_y < 5'(pic_pkg::NumAa));
  assign hit     = both_ok && (rd_x == rd_y);
  assign m_new   = cnt_m + {10'd0, hit};
  assign p_new   = cnt_p + {10'd0, both_ok};
  assign h_last  = ({1'b0, h} + 11'd1 == eff_s);
  assign pair_last_t = (pt == nt_m1);
  assign pair_last_s = (ps == TW'(nt_m1 - TW'(1)));

  // Matrix entry decode.
  logic          diag;
  logic [TW-1:0] lo, hi;
  logic [10:0]   pm_m, pm_p;
  assign diag = (es == et);
  assign lo   = (es < et) ? es : et;
  assign hi   = (es < et) ? et : es;
  assign pm_m = pm_rd[21:11];
  assign pm_p = pm_rd[10:0];

  // Shared multiplier.
  logic [26:0] mul_a;
  logic [13:0] mul_b;
  logic [40:0] prod;
  always_comb begin
    unique case (state)
      S_SUM:   begin mul_a = {13'd0, freq[acnt]}; mul_b = freq[acnt]; end
      S_NS2:   begin mul_a = {13'd0, ns};         mul_b = ns;         end
      S_EM1:   begin mul_a = ns2;                 mul_b = {3'd0, pm_m}; end
      S_EM2:   begin mul_a = qsum;                mul_b = {3'd0, pm_p}; end
      default: begin mul_a = ns2;                 mul_b = {3'd0, pm_p}; end
    endcase
  end
  assign prod = {14'd0, mul_a} * {27'd0, mul_b};

  // Divider step: the first step takes the integer bit without a shift.
  logic [DW-1:0] r_sh;
  logic          ge;
  assign r_sh = (dcnt == 5'd0) ? rem : {rem[DW-2:0], 1'b0};
  assign ge   = (r_sh >= den_r);

  logic [31:0] mag;
  assign mag = {1'b0, quo} + {31'd0, ({rem, 1'b0} >= {1'b0, den_r})};

  logic e_last;
  assign e_last = (es == nt_m1) && (et == nt_m1);

  // Memory ports.
  always_ff @(posedge clk) begin
    if (state == S_LDW) begin
      store[pos] <= ld_code;
    end
    if (state == S_LOAD) begin
      rd_x <= store[AW'(ld_site)];
    end else begin
      rd_x <= store[base_s + AW'(h)];
    end
    rd_y <= store[base_t + AW'(h)];
    if (state == S_SACC && h_last) begin
      pm_mem[{ps, pt}] <= {m_new, p_new};
    end
    pm_rd <= pm_mem[{lo, hi}];
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      taxa_reg  <= 4'd2;
      sites_reg <= 11'd1;
      pos       <= '0;
      ld_taxon  <= '0;
      ld_site   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < pic_pkg::NumAa; i++) freq[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pic_pkg::CfgTaxa:  taxa_reg  <= cfg_data[3:0];
          pic_pkg::CfgSites: sites_reg <= cfg_data;
          default: ;
        endcase
        // restart the load
        pos      <= '0;
        ld_taxon <= '0;
        ld_site  <= '0;
        for (int i = 0; i < pic_pkg::NumAa; i++) freq[i] <= '0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            ch_r  <= residue_char;
            state <= S_LDW;
          end
        end
        S_LDW: begin
          if (ld_code < 5'(pic_pkg::NumAa)) freq[ld_code] <= freq[ld_code] + 14'd1;
          if (ld_last) begin
            acnt  <= '0;
            ns    <= '0;
            qsum  <= '0;
            state <= S_SUM;
          end else begin
            pos <= pos + AW'(1);
            if ({1'b0, ld_site} + 11'd1 == eff_s) begin
              ld_site  <= '0;
              ld_taxon <= ld_taxon + TW'(1);
            end else begin
              ld_site <= ld_site + SW'(1);
            end
            state <= S_LOAD;
          end
        end
        S_SUM: begin
          ns   <= ns + freq[acnt];
          qsum <= qsum + prod[26:0];
          if (acnt == 5'(pic_pkg::NumAa - 1)) state <= S_NS2;
          else acnt <= acnt + 5'd1;
        end
        S_NS2: begin
          ns2    <= prod[26:0];
          ps     <= '0;
          pt     <= TW'(1);
          h      <= '0;
          base_s <= '0;
          base_t <= AW'(eff_s);
          cnt_m  <= '0;
          cnt_p  <= '0;
          es     <= '0;
          et     <= '0;
          state  <= (eff_t == 4'd1) ? S_ERD : S_SRD;
        end
        S_SRD: begin
          state <= S_SACC;
        end
        S_SACC: begin
          if (h_last) begin
            cnt_m <= '0;
            cnt_p <= '0;
            h     <= '0;
            if (pair_last_t) begin
              if (pair_last_s) begin
                state <= S_ERD;
              end else begin
                ps     <= ps + TW'(1);
                pt     <= ps + TW'(2);
                base_s <= base_s + AW'(eff_s);
                base_t <= base_s + AW'({eff_s, 1'b0});
                state  <= S_SRD;
              end
            end else begin
              pt     <= pt + TW'(1);
              base_t <= base_t + AW'(eff_s);
              state  <= S_SRD;
            end
          end else begin
            cnt_m <= m_new;
            cnt_p <= p_new;
            h     <= h + SW'(1);
            state <= S_SRD;
          end
        end
        S_ERD: begin
          state <= S_EM1;
        end
        S_EM1: begin
          if (diag) begin
            pos_r <= DW'(ns2);
            neg_r <= DW'(qsum);
            den_r <= DW'(ns2);
            state <= S_ESUB;
          end else begin
            pos_r <= prod[DW-1:0];
            state <= S_EM2;
          end
        end
        S_EM2: begin
          neg_r <= prod[DW-1:0];
          state <= S_EM3;
        end
        S_EM3: begin
          den_r <= prod[DW-1:0];
          state <= S_ESUB;
        end
        S_ESUB: begin
          if (ns == '0 || (!diag && pm_p == '0)) begin
            sigma_value    <= '0;
            undefined_flag <= 1'b1;
            out_valid      <= 1'b1;
            state          <= S_OUT;
          end else begin
            neg_sign <= (neg_r > pos_r);
            rem      <= (neg_r > pos_r) ? (neg_r - pos_r) : (pos_r - neg_r);
            quo      <= '0;
            dcnt     <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? (r_sh - den_r) : r_sh;
          quo <= {quo[29:0], ge};
          if (dcnt == 5'(pic_pkg::FracBits)) state <= S_RND;
          else dcnt <= dcnt + 5'd1;
        end
        S_RND: begin
          sigma_value    <= neg_sign ? (32'd0 - mag) : mag;
          undefined_flag <= 1'b0;
          out_valid      <= 1'b1;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (e_last) begin
              // drop back to loading for the next alignment
              pos      <= '0;
              ld_taxon <= '0;
              ld_site  <= '0;
              for (int i = 0; i < pic_pkg::NumAa; i++) freq[i] <= '0;
              state <= S_LOAD;
            end else begin
              if (et == nt_m1) begin
                et <= '0;
                es <= es + TW'(1);
              end else begin
                et <= et + TW'(1);
              end
              state <= S_ERD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign row_taxon  = es;
  assign col_taxon  = et;
  assign last_entry = e_last;

endmodule

// ----- rtl/pic_checker.sv -----
`timescale 1ns / 1ps
module pic_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  row_taxon,
  input logic [2:0]  col_taxon,
  input logic signed [31:0] sigma_value,
  input logic        undefined_flag,
  input logic        last_entry
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sigma_value))
    else $error("stalled result changed");

  // No input is taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during result");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && undefined_flag |-> sigma_value == 32'sd0)
    else $error("undefined entry with nonzero value");

  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_entry |-> row_taxon == col_taxon)
    else $error("last entry off the diagonal");

  a_diag_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_taxon == col_taxon |-> !sigma_value[31])
    else $error("negative diagonal entry");

endmodule

bind pairwise_identity_covariance_unit pic_checker u_pic_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .row_taxon(row_taxon),
  .col_taxon(col_taxon),
  .sigma_value(sigma_value),
  .undefined_flag(undefined_flag),
  .last_entry(last_entry)
);
